// ===== src/srs_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srs_pkg
// Shared constants, mode codes, lane control types and helpers of the
// stereo resample interpolator.
// ----------------------------------------------------------------------------
package srs_pkg;

	localparam int HISTORY_TAPS = 4;
	localparam int MAX_OUT      = 8;

	localparam logic [17:0] PHASE_ONE = 18'h10000;
	localparam logic [17:0] PHASE_MAX = 18'h3FFFF;
	localparam logic [17:0] STEP_RST  = 18'd28087;

	localparam logic [2:0] MODE_NONE    = 3'd0;
	localparam logic [2:0] MODE_ADAPT   = 3'd1;
	localparam logic [2:0] MODE_FIR     = 3'd3;
	localparam logic [2:0] MODE_CUBIC   = 3'd4;
	localparam logic [2:0] MODE_HERMITE = 3'd5;
	localparam logic [2:0] MODE_CATROM  = 3'd6;

	localparam logic [1:0] CFG_MODE   = 2'd0;
	localparam logic [1:0] CFG_STEP   = 2'd1;
	localparam logic [1:0] CFG_ENABLE = 2'd2;
	localparam logic [1:0] CFG_MONO   = 2'd3;

	typedef struct packed {
		logic        store;
		logic        shift;
		logic [1:0]  wpos;
		logic [15:0] sample;
		logic        start;
		logic [2:0]  mode;
		logic [1:0]  pos;
		logic [15:0] mu;
		logic [17:0] sinc;
		logic [16:0] recip;
	} lane_ctl_t;

	typedef struct packed {
		logic        rdy;
		logic [15:0] value;
	} lane_res_t;

	function automatic logic [15:0] clamp16(input logic signed [31:0] v);
		logic [15:0] r;
		if (v > 32'sd32767) begin
			r = 16'h7FFF;
		end else if (v < -32'sd32768) begin
			r = 16'h8000;
		end else begin
			r = v[15:0];
		end
		return r;
	endfunction

endpackage

// ===== src/stereo_audio_resample_interpolator_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stereo_audio_resample_interpolator_core
// Stereo fractional-phase resampler: two channel lanes run side by side and
// an output register merges their results into one stereo request.
// ----------------------------------------------------------------------------
// a new input is taken only in idle, once every output of the last input has
// been loaded; each input gives n <= 8 outputs, and adaptive mode runs the
// serial reciprocal division per input first. Each lane computes with its
// shared multiplier, and a stalled output holds the flow
// reset: phase one, history, chains and registers to their reset values
module stereo_audio_resample_interpolator_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [17:0] cfg_data,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,  // sample_left, sample_right
	input  logic        s_tuser,  // sector_start
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,  // out_left, out_right
	output logic        m_tlast   // end_of_run
);

	typedef enum logic [1:0] {S_IDLE, S_DIV, S_CHECK, S_WAIT} state_t;

	state_t      state_q;
	logic [2:0]  mode_q;
	logic [17:0] step_q;
	logic        enable_q, mono_q;
	logic [17:0] phase_q;
	logic [1:0]  pos_q;
	logic [3:0]  n_q;
	logic [16:0] recip_q;
	logic        last_q;
	logic        m_tvalid_q, m_tlast_q;
	logic [31:0] m_tdata_q;

	logic               accept, go, load, div_done;
	logic [16:0]        div_quo;
	logic [15:0]        v_l, v_r;
	logic [18:0]        ph_sum;
	logic [17:0]        ph_next;
	srs_pkg::lane_ctl_t ctl_l, ctl_r;
	srs_pkg::lane_res_t res_l, res_r;

	assign s_tready = (state_q == S_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign v_l      = enable_q ? s_tdata[15:0] : 16'h0;
	assign v_r      = enable_q ? (mono_q ? s_tdata[15:0] : s_tdata[31:16]) : 16'h0;
	assign go       = (state_q == S_CHECK) && (phase_q < srs_pkg::PHASE_ONE) && !n_q[3];
	assign ph_sum   = {1'b0, phase_q} + {1'b0, step_q};
	assign ph_next  = ph_sum[18] ? srs_pkg::PHASE_MAX : ph_sum[17:0];
	assign load     = (state_q == S_WAIT) && res_l.rdy && res_r.rdy &&
		(!m_tvalid_q || m_tready);

	always_comb begin
		ctl_l.store  = accept;
		ctl_l.shift  = (mode_q == srs_pkg::MODE_ADAPT);
		ctl_l.wpos   = pos_q;
		ctl_l.sample = v_l;
		ctl_l.start  = go;
		ctl_l.mode   = mode_q;
		ctl_l.pos    = pos_q;
		ctl_l.mu     = phase_q[15:0];
		ctl_l.sinc   = (step_q == '0) ? srs_pkg::PHASE_ONE : step_q;
		ctl_l.recip  = recip_q;
		ctl_r        = ctl_l;
		ctl_r.sample = v_r;
	end

	srs_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (accept && (mode_q == srs_pkg::MODE_ADAPT)),
		.divisor  (ctl_l.sinc),
		.done     (div_done),
		.quotient (div_quo)
	);

	srs_lane u_lane_l (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl_l),
		.res    (res_l)
	);

	srs_lane u_lane_r (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl_r),
		.res    (res_r)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			mode_q     <= srs_pkg::MODE_NONE;
			step_q     <= srs_pkg::STEP_RST;
			enable_q   <= 1'b0;
			mono_q     <= 1'b0;
			phase_q    <= srs_pkg::PHASE_ONE;
			pos_q      <= '0;
			n_q        <= '0;
			recip_q    <= '0;
			last_q     <= 1'b0;
			m_tvalid_q <= 1'b0;
			m_tlast_q  <= 1'b0;
			m_tdata_q  <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					srs_pkg::CFG_MODE:   mode_q   <= cfg_data[2:0];
					srs_pkg::CFG_STEP:   step_q   <= cfg_data;
					srs_pkg::CFG_ENABLE: enable_q <= cfg_data[0];
					srs_pkg::CFG_MONO:   mono_q   <= cfg_data[0];
					default: ;
				endcase
			end
			if (load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (s_tuser || phase_q < srs_pkg::PHASE_ONE) begin
							phase_q <= '0;
						end else begin
							phase_q <= phase_q - srs_pkg::PHASE_ONE;
						end
						if (mode_q >= 3'd2) pos_q <= pos_q + 2'd1;
						n_q     <= '0;
						state_q <= (mode_q == srs_pkg::MODE_ADAPT) ? S_DIV : S_CHECK;
					end
				end
				S_DIV: begin
					if (div_done) begin
						recip_q <= div_quo;
						state_q <= S_CHECK;
					end
				end
				S_CHECK: begin
					if (go) begin
						phase_q <= ph_next;
						last_q  <= (ph_next >= srs_pkg::PHASE_ONE) || (n_q == 4'd7);
						state_q <= S_WAIT;
					end else begin
						state_q <= S_IDLE;
					end
				end
				S_WAIT: begin
					if (load) begin
						m_tdata_q  <= {res_r.value, res_l.value};
						m_tlast_q  <= last_q;
						n_q        <= n_q + 4'd1;
						state_q    <= S_CHECK;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tlast  = m_tlast_q;

endmodule

// ===== src/srs_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srs_div
// Restoring divider, one quotient bit a cycle: 0x10000 / divisor.
// ----------------------------------------------------------------------------
module srs_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [17:0] divisor,
	output logic        done,
	output logic [16:0] quotient
);

	logic        busy_q;
	logic [4:0]  cnt_q;
	logic [16:0] num_q;
	logic [17:0] rem_q;
	logic [16:0] quo_q;
	logic        done_q;
	logic [18:0] trial;
	logic        ge;

	assign trial = {rem_q, num_q[16]};
	assign ge    = trial >= {1'b0, divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			num_q  <= '0;
			rem_q  <= '0;
			quo_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 5'd17;
				num_q  <= srs_pkg::PHASE_ONE[16:0];
				rem_q  <= '0;
				quo_q  <= '0;
			end else if (busy_q) begin
				num_q <= {num_q[15:0], 1'b0};
				if (ge) begin
					rem_q <= 18'(trial - {1'b0, divisor});
				end else begin
					rem_q <= trial[17:0];
				end
				quo_q <= {quo_q[15:0], ge};
				cnt_q <= cnt_q - 5'd1;
				if (cnt_q == 5'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

// ===== src/srs_lane.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srs_lane
// One channel: 4-tap history, adaptive step chain and a shared multiplier
// that runs the three Horner passes of the polynomial kernels.
// ----------------------------------------------------------------------------
module srs_lane (
	input  logic               clk,
	input  logic               arst_n,
	input  srs_pkg::lane_ctl_t ctl,
	output srs_pkg::lane_res_t res
);

	typedef enum logic [2:0] {
		L_IDLE, L_SETUP, L_MUL, L_SHF, L_ADAPT, L_ADIV, L_AST, L_ACUR
	} lstate_t;

	lstate_t            state_q;
	logic [15:0]        hist_q [4];
	logic signed [31:0] step_q, cur_q;
	logic [15:0]        next_q, after_q;
	logic [1:0]         flag_q;
	logic [1:0]         pass_q;
	logic signed [31:0] v_q, prod_q, base_q;
	logic signed [31:0] coef_q [3];
	logic signed [18:0] mult_q [3];
	logic               sh15_q, sh17_q;
	logic [15:0]        mu_q;
	logic [15:0]        res_q;
	logic               rdy_q;

	logic [63:0]        win;
	logic [127:0]       win2;
	logic signed [31:0] y0, y1, y2, y3;
	logic signed [31:0] nx, af, d1, d2, d1x2;
	logic signed [31:0] step_new, ma, vs, fir, m0, m1;
	logic signed [18:0] mb, sinc_s, mu_s, xd6, xh, xd_s;
	logic signed [50:0] product;
	logic [15:0]        xd;
	logic [16:0]        nq;
	logic [34:0]        qprod;
	logic               d1pos, special, half;

	assign win  = {hist_q[3], hist_q[2], hist_q[1], hist_q[0]};
	assign win2 = {win, win} >> {ctl.pos, 4'b0};
	assign y0   = 32'(signed'(win2[15:0]));
	assign y1   = 32'(signed'(win2[31:16]));
	assign y2   = 32'(signed'(win2[47:32]));
	assign y3   = 32'(signed'(win2[63:48]));

	// kernel helpers
	assign m0   = ((y1 - y0) >>> 2) + ((y2 - y1) >>> 2);
	assign m1   = ((y2 - y1) >>> 2) + ((y3 - y2) >>> 2);
	assign fir  = y3 * 32'sd4807 + y2 * 32'sd22963 + y1 * 32'sd4871 - y0;
	assign xd   = {1'b0, mu_q[15:1]} + 16'd1;
	assign nq   = 17'(18'h10000 - {2'b0, xd});
	assign qprod = nq * 18'd43691;
	assign xd6  = -signed'({2'b0, qprod[34:18]});
	assign xh   = 19'(($signed({3'b0, xd}) - 19'sd32768) >>> 1);
	assign xd_s = signed'({3'b0, xd});
	assign mu_s = signed'({3'b0, mu_q});

	// adaptive chain
	assign nx     = 32'(signed'(next_q));
	assign af     = 32'(signed'(after_q));
	assign d1     = nx - cur_q;
	assign d2     = af - nx;
	assign d1x2   = d1 <<< 1;
	assign d1pos  = d1 > 32'sd0;
	assign special = d1pos ? (d2 < d1) : (d2 > d1);
	assign half   = d1pos ? !(d2 < d1x2) : !(d2 > d1x2);
	assign sinc_s = signed'({1'b0, ctl.sinc});
	assign step_new = (prod_q + (prod_q[31] ? 32'sd131071 : 32'sd0)) >>> 17;

	always_comb begin
		ma = '0;
		mb = '0;
		unique case (state_q)
			L_MUL: begin
				ma = coef_q[pass_q] + v_q;
				mb = mult_q[pass_q];
			end
			L_ADAPT: begin
				ma = (flag_q == 2'd1) ? d1 : step_q;
				mb = sinc_s;
			end
			L_AST: begin
				ma = step_new;
				mb = signed'({2'b0, ctl.recip}) - 19'sd1;
			end
			default: begin
				ma = '0;
				mb = '0;
			end
		endcase
	end

	assign product = ma * mb;
	assign vs      = sh15_q ? (prod_q >>> 15) : (prod_q >>> 16);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= L_IDLE;
			for (int i = 0; i < 4; i++) hist_q[i] <= '0;
			for (int i = 0; i < 3; i++) begin
				coef_q[i] <= '0;
				mult_q[i] <= '0;
			end
			step_q  <= '0;
			cur_q   <= '0;
			next_q  <= '0;
			after_q <= '0;
			flag_q  <= '0;
			pass_q  <= '0;
			v_q     <= '0;
			prod_q  <= '0;
			base_q  <= '0;
			sh15_q  <= 1'b0;
			sh17_q  <= 1'b0;
			mu_q    <= '0;
			res_q   <= '0;
			rdy_q   <= 1'b0;
		end else begin
			if (ctl.store) begin
				for (int i = 0; i < 4; i++) begin
					if (ctl.wpos == 2'(i)) hist_q[i] <= ctl.sample;
				end
				if (ctl.shift) begin
					step_q  <= '0;
					cur_q   <= nx;
					next_q  <= after_q;
					after_q <= ctl.sample;
					flag_q  <= 2'd1;
				end
			end
			unique case (state_q)
				L_IDLE: begin
					if (ctl.start) begin
						rdy_q   <= 1'b0;
						mu_q    <= ctl.mu;
						state_q <= (ctl.mode == srs_pkg::MODE_ADAPT) ? L_ADAPT : L_SETUP;
					end
				end
				L_SETUP: begin
					pass_q <= '0;
					v_q    <= '0;
					sh15_q <= (ctl.mode == srs_pkg::MODE_CUBIC);
					if (ctl.mode == srs_pkg::MODE_CATROM) begin
						coef_q[0] <= (-y0 + 3 * y1 - 3 * y2 + y3) >>> 1;
						coef_q[1] <= (2 * y0 - 5 * y1 + 4 * y2 - y3) >>> 1;
						coef_q[2] <= (y2 - y0) >>> 1;
						for (int i = 0; i < 3; i++) mult_q[i] <= mu_s;
						base_q  <= y1;
						state_q <= L_MUL;
					end else if (ctl.mode == srs_pkg::MODE_HERMITE) begin
						coef_q[0] <= 2 * y1 + m0 + m1 - 2 * y2;
						coef_q[1] <= -3 * y1 - 2 * m0 - m1 + 3 * y2;
						coef_q[2] <= m0;
						for (int i = 0; i < 3; i++) mult_q[i] <= mu_s;
						base_q  <= y1;
						state_q <= L_MUL;
					end else if (ctl.mode == srs_pkg::MODE_CUBIC) begin
						coef_q[0] <= y3 - 3 * y2 + 3 * y1 - y0;
						coef_q[1] <= y2 - 2 * y1 + y0;
						coef_q[2] <= y1 - y0;
						mult_q[0] <= xd6;
						mult_q[1] <= xh;
						mult_q[2] <= xd_s;
						base_q  <= y0;
						state_q <= L_MUL;
					end else begin
						res_q   <= (ctl.mode == srs_pkg::MODE_FIR) ?
							srs_pkg::clamp16(fir >>> 15) : srs_pkg::clamp16(y0);
						rdy_q   <= 1'b1;
						state_q <= L_IDLE;
					end
				end
				L_MUL: begin
					prod_q  <= product[31:0];
					state_q <= L_SHF;
				end
				L_SHF: begin
					if (pass_q == 2'd2) begin
						res_q   <= srs_pkg::clamp16(base_q + vs);
						rdy_q   <= 1'b1;
						state_q <= L_IDLE;
					end else begin
						v_q     <= vs;
						pass_q  <= pass_q + 2'd1;
						state_q <= L_MUL;
					end
				end
				L_ADAPT: begin
					if (flag_q == 2'd1) begin
						if (special) begin
							step_q  <= d1;
							flag_q  <= 2'd2;
							res_q   <= srs_pkg::clamp16(cur_q);
							rdy_q   <= 1'b1;
							state_q <= L_IDLE;
						end else begin
							flag_q  <= 2'd0;
							sh17_q  <= half;
							prod_q  <= product[31:0];
							state_q <= L_ADIV;
						end
					end else if (flag_q == 2'd2) begin
						flag_q  <= 2'd0;
						prod_q  <= product[31:0];
						state_q <= L_AST;
					end else begin
						cur_q   <= cur_q + step_q;
						res_q   <= srs_pkg::clamp16(cur_q + step_q);
						rdy_q   <= 1'b1;
						state_q <= L_IDLE;
					end
				end
				L_ADIV: begin
					if (sh17_q) begin
						step_q <= step_new;
					end else begin
						step_q <= (prod_q + (prod_q[31] ? 32'sd65535 : 32'sd0)) >>> 16;
					end
					res_q   <= srs_pkg::clamp16(cur_q);
					rdy_q   <= 1'b1;
					state_q <= L_IDLE;
				end
				L_AST: begin
					step_q <= step_new;
					if (ctl.sinc <= 18'h08000) begin
						prod_q  <= product[31:0];
						state_q <= L_ACUR;
					end else begin
						cur_q   <= cur_q + step_new;
						res_q   <= srs_pkg::clamp16(cur_q + step_new);
						rdy_q   <= 1'b1;
						state_q <= L_IDLE;
					end
				end
				L_ACUR: begin
					cur_q   <= nx - prod_q;
					res_q   <= srs_pkg::clamp16(nx - prod_q);
					rdy_q   <= 1'b1;
					state_q <= L_IDLE;
				end
				default: state_q <= L_IDLE;
			endcase
		end
	end

	assign res.rdy   = rdy_q;
	assign res.value = res_q;

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the stereo resample interpolator core. A scoreboard
// class predicts every output request from each accepted input request and
// checks the output stream in order, over all interpolation modes, step
// sizes, mute, mono and sector starts, under random idling on both streams.
// ----------------------------------------------------------------------------
module tb_top;

	typedef struct {
		logic [15:0] left;
		logic [15:0] right;
		logic        last;
	} stereo_out_t;

	class resample_scoreboard;
		logic [2:0]  mode;
		int unsigned step_size;
		bit          enable;
		bit          mono;
		int unsigned phase;
		int          hist[8];
		int unsigned wpos;
		int          ch_step[2];
		int          ch_cur[2];
		int          ch_next[2];
		int          ch_after[2];
		int unsigned ch_flag[2];
		stereo_out_t pending[$];
		int          errors;
		int          matched;

		function new();
			mode = srs_pkg::MODE_NONE;
			step_size = srs_pkg::STEP_RST;
			enable = 0;
			mono = 0;
			phase = srs_pkg::PHASE_ONE;
			wpos = 0;
			errors = 0;
			matched = 0;
			for (int i = 0; i < 8; i++) hist[i] = 0;
			for (int c = 0; c < 2; c++) begin
				ch_step[c] = 0; ch_cur[c] = 0; ch_next[c] = 0;
				ch_after[c] = 0; ch_flag[c] = 0;
			end
		endfunction

		function void set_reg(logic [1:0] idx, logic [17:0] val);
			case (idx)
				srs_pkg::CFG_MODE:   mode = val[2:0];
				srs_pkg::CFG_STEP:   step_size = val;
				srs_pkg::CFG_ENABLE: enable = val[0];
				srs_pkg::CFG_MONO:   mono = val[0];
			endcase
		endfunction

		function void adapt_chain(int c, int sinc);
			int d1, d2, d1x2;
			if (sinc == 0) sinc = 65536;
			if (ch_flag[c] == 1) begin
				d1 = ch_next[c] - ch_cur[c];
				d2 = ch_after[c] - ch_next[c];
				d1x2 = d1 << 1;
				ch_flag[c] = 0;
				if (d1 > 0) begin
					if (d2 < d1) begin
						ch_step[c] = d1; ch_flag[c] = 2;
					end else if (d2 < d1x2) ch_step[c] = (d1 * sinc) / 65536;
					else ch_step[c] = (d1 * sinc) / 131072;
				end else begin
					if (d2 > d1) begin
						ch_step[c] = d1; ch_flag[c] = 2;
					end else if (d2 > d1x2) ch_step[c] = (d1 * sinc) / 65536;
					else ch_step[c] = (d1 * sinc) / 131072;
				end
			end else if (ch_flag[c] == 2) begin
				ch_flag[c] = 0;
				ch_step[c] = (ch_step[c] * sinc) / 131072;
				if (sinc <= 32768) ch_cur[c] = ch_next[c] - ch_step[c] * ((65536 / sinc) - 1);
				else ch_cur[c] = ch_cur[c] + ch_step[c];
			end else begin
				ch_cur[c] = ch_cur[c] + ch_step[c];
			end
		endfunction

		function int interpolate(int c, int mu);
			int y0, y1, y2, y3, v, a1, a2, a3, m0, m1, xd;
			y0 = hist[c * 4 + ((wpos + 0) & 3)];
			y1 = hist[c * 4 + ((wpos + 1) & 3)];
			y2 = hist[c * 4 + ((wpos + 2) & 3)];
			y3 = hist[c * 4 + ((wpos + 3) & 3)];
			case (mode)
				srs_pkg::MODE_CATROM: begin
					a3 = (-y0 + 3 * y1 - 3 * y2 + y3) >>> 1;
					a2 = (2 * y0 - 5 * y1 + 4 * y2 - y3) >>> 1;
					a1 = (-y0 + y2) >>> 1;
					v = (a3 * mu) >>> 16;
					v = ((a2 + v) * mu) >>> 16;
					v = ((a1 + v) * mu) >>> 16;
					return y1 + v;
				end
				srs_pkg::MODE_HERMITE: begin
					m0 = (((y1 - y0) * 16384) >>> 16) + (((y2 - y1) * 16384) >>> 16);
					m1 = (((y2 - y1) * 16384) >>> 16) + (((y3 - y2) * 16384) >>> 16);
					v = ((2 * y1 + m0 + m1 - 2 * y2) * mu) >>> 16;
					v = ((v - 3 * y1 - 2 * m0 - m1 + 3 * y2) * mu) >>> 16;
					v = ((v + m0) * mu) >>> 16;
					return v + y1;
				end
				srs_pkg::MODE_CUBIC: begin
					xd = (mu >>> 1) + 1;
					v = y3 - 3 * y2 + 3 * y1 - y0;
					v = (v * ((xd - 65536) / 6)) >>> 15;
					v = v + y2 - 2 * y1 + y0;
					v = (v * ((xd - 32768) >>> 1)) >>> 15;
					v = v + y1 - y0;
					v = (v * xd) >>> 15;
					return v + y0;
				end
				srs_pkg::MODE_FIR: return (y3 * 4807 + y2 * 22963 + y1 * 4871 - y0) >>> 15;
				srs_pkg::MODE_ADAPT: begin
					adapt_chain(c, int'(step_size));
					return ch_cur[c];
				end
				default: return y0;
			endcase
		endfunction

		function logic [15:0] sat16(int v);
			if (v > 32767) return 16'h7FFF;
			if (v < -32768) return 16'h8000;
			return v[15:0];
		endfunction

		function void note_input(logic [15:0] l, logic [15:0] r, bit sstart);
			int vs[2];
			int n;
			stereo_out_t e;
			vs[0] = int'($signed(l));
			vs[1] = mono ? vs[0] : int'($signed(r));
			if (!enable) begin
				vs[0] = 0; vs[1] = 0;
			end
			if (sstart) phase = srs_pkg::PHASE_ONE;
			phase = (phase >= srs_pkg::PHASE_ONE) ? phase - srs_pkg::PHASE_ONE : 0;
			hist[wpos] = vs[0];
			hist[4 + wpos] = vs[1];
			if (mode >= 2) begin
				wpos = (wpos + 1) & 3;
			end else if (mode == srs_pkg::MODE_ADAPT) begin
				for (int c = 0; c < 2; c++) begin
					ch_step[c] = 0;
					ch_cur[c] = ch_next[c];
					ch_next[c] = ch_after[c];
					ch_after[c] = vs[c];
					ch_flag[c] = 1;
				end
			end
			n = 0;
			while (phase < srs_pkg::PHASE_ONE && n < srs_pkg::MAX_OUT) begin
				e.left = sat16(interpolate(0, int'(phase)));
				e.right = sat16(interpolate(1, int'(phase)));
				e.last = 0;
				pending.push_back(e);
				phase = phase + step_size;
				if (phase > srs_pkg::PHASE_MAX) phase = srs_pkg::PHASE_MAX;
				n++;
			end
			if (n > 0) pending[$].last = 1;
		endfunction

		function void check(logic [31:0] data, logic last);
			stereo_out_t e;
			if (pending.size() == 0) begin
				errors++;
				if (errors <= 10) $display("unexpected output request %h last %b", data, last);
				return;
			end
			e = pending.pop_front();
			if (data[15:0] !== e.left || data[31:16] !== e.right || last !== e.last) begin
				errors++;
				if (errors <= 10)
					$display("mismatch: expected l %h r %h last %b, got l %h r %h last %b",
						e.left, e.right, e.last, data[15:0], data[31:16], last);
			end else begin
				matched++;
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [1:0]  cfg_index;
	logic [17:0] cfg_data;
	logic        s_tvalid;
	logic        s_tready;
	logic [31:0] s_tdata;
	logic        s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [31:0] m_tdata;
	logic        m_tlast;

	resample_scoreboard sb;
	int          tx_idle;
	int          rx_idle;
	int          cycles;
	int          sent;
	int          settings;

	localparam int CYCLE_LIMIT = 2000000;

	stereo_audio_resample_interpolator_core i_dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
	);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > CYCLE_LIMIT) begin
				$display("FAIL");
				$finish;
			end
		end
	end

	// output side
	initial begin
		m_tready = 0;
		forever begin
			@(posedge clk);
			if (arst_n && m_tvalid && m_tready) sb.check(m_tdata, m_tlast);
			@(negedge clk);
			m_tready = ($urandom_range(99) >= rx_idle);
		end
	end

	task automatic send_sample(logic [15:0] l, logic [15:0] r, bit sstart);
		while ($urandom_range(99) < tx_idle) begin
			s_tvalid = 0;
			@(negedge clk);
		end
		s_tvalid = 1;
		s_tdata = {r, l};
		s_tuser = sstart;
		do @(posedge clk); while (!s_tready);
		sb.note_input(l, r, sstart);
		sent++;
		@(negedge clk);
	endtask

	task automatic drain();
		s_tvalid = 0;
		while (sb.pending.size() != 0) @(negedge clk);
		repeat (200) @(negedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [17:0] val);
		cfg_we = 1;
		cfg_index = idx;
		cfg_data = val;
		sb.set_reg(idx, val);
		@(negedge clk);
		cfg_we = 0;
	endtask

	task automatic apply_setting(logic [2:0] md, logic [17:0] stp, bit en, bit mn);
		drain();
		write_reg(srs_pkg::CFG_MODE, {15'd0, md});
		write_reg(srs_pkg::CFG_STEP, stp);
		write_reg(srs_pkg::CFG_ENABLE, {17'd0, en});
		write_reg(srs_pkg::CFG_MONO, {17'd0, mn});
		settings++;
	endtask

	function automatic logic [15:0] pick_sample();
		case ($urandom_range(5))
			0: return 16'h7FFF;
			1: return 16'h8000;
			2: return 16'($urandom_range(511)) - 16'd256;
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic logic [17:0] pick_step();
		case ($urandom_range(9))
			0: return 18'd8192;
			1: return 18'd131072;
			2: return ($urandom_range(3) == 0) ? 18'd0 : srs_pkg::PHASE_MAX;
			default: return 18'($urandom_range(131072, 8192));
		endcase
	endfunction

	initial begin
		logic [17:0] dir_step[8];
		sb = new();
		sent = 0;
		settings = 0;
		tx_idle = 25;
		rx_idle = 57;
		arst_n = 0;
		cfg_we = 0;
		cfg_index = srs_pkg::CFG_MODE;
		cfg_data = 0;
		s_tvalid = 0;
		s_tdata = 0;
		s_tuser = 0;
		repeat (5) @(negedge clk);
		arst_n = 1;
		@(negedge clk);

		// reset defaults: muted, no interpolation
		send_sample(16'h7FFF, 16'h8000, 1);
		dir_step = '{18'd0, 18'd0, 18'd8192, 18'd131072, srs_pkg::PHASE_MAX,
			18'd28087, 18'd8192, 18'd40000};
		for (int m = 0; m < 8; m++) begin
			apply_setting(3'(m), dir_step[m], 1, m == 6);
			send_sample(16'h7FFF, 16'h8000, 1);
			send_sample(16'h8000, 16'h7FFF, 0);
			send_sample(16'h1234, 16'hFFFF, 0);
		end

		while (sent < 450) begin
			if (sent > 310) begin
				tx_idle = 0; rx_idle = 0;
			end else if (sent > 155) begin
				tx_idle = 57; rx_idle = 25;
			end
			apply_setting(3'($urandom_range(7)), pick_step(), $urandom_range(7) != 0,
				$urandom_range(3) == 0);
			repeat ($urandom_range(40, 15))
				send_sample(pick_sample(), pick_sample(), $urandom_range(9) == 0);
		end
		drain();

		$display("%0d input requests over %0d settings, %0d output requests checked",
			sent, settings, sb.matched);
		if (sb.errors == 0 && sb.pending.size() == 0) begin
			$display("PASS");
		end else begin
			$display("%0d errors, %0d outputs missing", sb.errors, sb.pending.size());
			$display("FAIL");
		end
		$finish;
	end

endmodule
